// ----- hdl/prsw_pkg.sv -----
// Shared types, codes and constants for the partial-reliability stop-and-wait sender.
// No dependencies; every other file but prsw_fifo imports this package.
package prsw_pkg;

  localparam int WINDOW_DEF = 16;
  localparam int TOL_W      = 7;
  localparam int LOSS_W     = 7;
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 7'd30;
  localparam logic [TOL_W-1:0] TOL_MAX   = 7'd100;

  typedef enum logic [1:0] {
    OP_SEND      = 2'd0,
    OP_ACK       = 2'd1,
    OP_TIMEOUT   = 2'd2,
    OP_HANDSHAKE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_TRANSMIT   = 3'd0,
    ACT_RETRANSMIT = 3'd1,
    ACT_GAVE_UP    = 3'd2,
    ACT_DELIVERED  = 3'd3,
    ACT_IGNORED    = 3'd4,
    ACT_CONNECTED  = 3'd5,
    ACT_REFUSED    = 3'd6
  } act_t;

  typedef struct packed {
    op_t              op;
    logic             ack_bit;
    logic [TOL_W-1:0] peer_tolerance;
  } in_item_t;

  typedef struct packed {
    act_t              action;
    logic              seq_bit;
    logic [LOSS_W-1:0] losses_in_window;
    logic [TOL_W-1:0]  tolerance_in_use;
  } out_item_t;

  // Classified event handed from front to back
  typedef struct packed {
    op_t              kind;
    logic             ack_bit;
    logic [TOL_W-1:0] peer_sat;
  } cmd_t;

  function automatic logic [TOL_W-1:0] sat100(input logic [TOL_W-1:0] v);
    return (v > TOL_MAX) ? TOL_MAX : v;
  endfunction

endpackage

// ----- hdl/prsw_fifo.sv -----
// Small register-based queue with a combinational head, used between stages.
// Depends on nothing but its parameters.
module prsw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hdl/prsw_front.sv -----
// Front end: accepts input items and classifies them into commands for the back end.
// Depends on prsw_pkg.
module prsw_front (
  input  prsw_pkg::in_item_t in_item,
  output prsw_pkg::cmd_t     cmd
);
  import prsw_pkg::*;

  // Classify the event and saturate the peer's offer ahead of execution
  always_comb begin
    cmd.kind     = in_item.op;
    cmd.ack_bit  = 1'b0;
    cmd.peer_sat = '0;
    unique case (in_item.op)
      OP_ACK:       cmd.ack_bit  = in_item.ack_bit;
      OP_HANDSHAKE: cmd.peer_sat = sat100(in_item.peer_tolerance);
      OP_SEND, OP_TIMEOUT: ;
      default: ;
    endcase
  end

endmodule

// ----- hdl/prsw_back.sv -----
// Back end: link state, outcome window, loss count and the give-up decision.
// Depends on prsw_pkg; takes commands from the front queue, one per cycle while exec is high.
module prsw_back #(
  parameter int WINDOW = prsw_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          exec,
  input  prsw_pkg::cmd_t                cmd,
  input  logic                          tol_we,
  input  logic [prsw_pkg::TOL_W-1:0]    tol_wdata,
  output prsw_pkg::out_item_t           result
);
  import prsw_pkg::*;

  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LCNT_W = $clog2(WINDOW + 1);
  localparam int PROD_W = TOL_W + LCNT_W;

  logic              seq_r, seq_nxt;
  logic              await_r, await_nxt;
  logic              conn_r, conn_nxt;
  logic [WINDOW-1:0] win_r, win_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic [LCNT_W-1:0] loss_r, loss_nxt;
  logic [TOL_W-1:0]  fin_r, fin_nxt;
  logic [TOL_W-1:0]  ltol_r;
  logic              old_mark;
  logic [LCNT_W-1:0] loss_lost;
  logic [PROD_W-1:0] loss_pct, tol_pct;
  act_t              action;
  logic              seq_out;

  assign old_mark  = win_r[pos_r];
  assign pos_inc   = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
  // Loss count once the current slot is marked lost
  assign loss_lost = old_mark ? loss_r + 1'b1 : loss_r;
  assign loss_pct  = PROD_W'(loss_lost) * PROD_W'(TOL_MAX);
  assign tol_pct   = PROD_W'(fin_r) * PROD_W'(WINDOW);

  // Execute one command
  always_comb begin
    seq_nxt   = seq_r;
    await_nxt = await_r;
    conn_nxt  = conn_r;
    win_nxt   = win_r;
    pos_nxt   = pos_r;
    loss_nxt  = loss_r;
    fin_nxt   = fin_r;
    action    = ACT_IGNORED;
    seq_out   = 1'b0;
    unique case (cmd.kind)
      OP_SEND: begin
        if (!conn_r) begin
          action = ACT_REFUSED;
        end else if (!await_r) begin
          action    = ACT_TRANSMIT;
          seq_out   = seq_r;
          seq_nxt   = ~seq_r;
          await_nxt = 1'b1;
        end
      end
      OP_ACK: begin
        if (await_r && (cmd.ack_bit == seq_r)) begin
          if (!old_mark && (loss_r != '0)) begin
            loss_nxt = loss_r - 1'b1;
          end
          win_nxt[pos_r] = 1'b1;
          pos_nxt        = pos_inc;
          await_nxt      = 1'b0;
          action         = ACT_DELIVERED;
          seq_out        = ~seq_r;
        end
      end
      OP_TIMEOUT: begin
        if (await_r) begin
          win_nxt[pos_r] = 1'b0;
          loss_nxt       = loss_lost;
          seq_out        = ~seq_r;
          if (loss_pct <= tol_pct) begin
            action    = ACT_GAVE_UP;
            seq_nxt   = ~seq_r;
            pos_nxt   = pos_inc;
            await_nxt = 1'b0;
          end else begin
            action = ACT_RETRANSMIT;
          end
        end
      end
      OP_HANDSHAKE: begin
        if (!await_r) begin
          fin_nxt  = (cmd.peer_sat < sat100(ltol_r)) ? cmd.peer_sat : sat100(ltol_r);
          conn_nxt = 1'b1;
          action   = ACT_CONNECTED;
        end
      end
      default: ;
    endcase
  end

  assign result.action           = action;
  assign result.seq_bit          = seq_out;
  assign result.losses_in_window = LOSS_W'(loss_nxt);
  assign result.tolerance_in_use = fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= 1'b0;
      await_r <= 1'b0;
      conn_r  <= 1'b0;
      win_r   <= '1;
      pos_r   <= '0;
      loss_r  <= '0;
      fin_r   <= '0;
    end else if (exec) begin
      seq_r   <= seq_nxt;
      await_r <= await_nxt;
      conn_r  <= conn_nxt;
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      loss_r  <= loss_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Local tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ltol_r <= TOL_RESET;
    end else if (tol_we) begin
      ltol_r <= tol_wdata;
    end
  end

endmodule

// ----- hdl/partial_reliability_stop_and_wait_top.sv -----
// Usage
// Sender side of an alternating-bit stop-and-wait link that tolerates a share of losses.
// Input channel: in_data (op, ack_bit, peer_tolerance) is transferred when in_push is
// high and in_full is low. Every input item gives exactly one result.
// Result channel: while out_empty is low the oldest result (action, seq_bit,
// losses_in_window, tolerance_in_use) is on out_data; it is transferred when out_pop
// is high. Configuration: cfg_data (local tolerance) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while the block is idle.
// Each input is registered in the command queue and its result in the output queue.
// Throughput: one item per cycle while the output queue has room, set by the update of
// the link state and the running loss count in the back end.
// The front end classifies into a two-entry command queue; results sit in a two-entry
// output queue. When the receiver stalls, the output queue fills, the back end holds,
// and in_full rises once the command queue is also full; nothing is dropped.
// Reset (rst_n low, synchronous): queues empty, link not connected, outcome window all
// received, loss count and negotiated tolerance zero, local tolerance 30.
module partial_reliability_stop_and_wait_top #(
  parameter int WINDOW = prsw_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  prsw_pkg::in_item_t         in_data,
  output logic                       in_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output prsw_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [prsw_pkg::TOL_W-1:0] cfg_data
);
  import prsw_pkg::*;

  cmd_t      cmd_in, cmd_head;
  out_item_t result;
  logic      cmd_empty, out_full, exec;

  assign cfg_ready = 1'b1;
  // Execute when a command waits and the result has room
  assign exec = !cmd_empty && !out_full;

  prsw_front u_front (
    .in_item (in_data),
    .cmd     (cmd_in)
  );

  prsw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (exec),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  prsw_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec      (exec),
    .cmd       (cmd_head),
    .tol_we    (cfg_valid && cfg_ready),
    .tol_wdata (cfg_data),
    .result    (result)
  );

  prsw_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (exec),
    .wdata (result),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

// ----- bench/tb_partial_reliability_stop_and_wait_top.sv -----
// Self-checking bench for the partial-reliability stop-and-wait sender: directed link events,
// then random, mostly well-formed message exchanges under several tolerances and idling patterns.
// Depends on prsw_pkg and partial_reliability_stop_and_wait_top.
module tb_partial_reliability_stop_and_wait_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prsw_pkg::*;

  localparam int WIN              = WINDOW_DEF;
  localparam int SLOT_W           = $clog2(WIN);
  localparam int HOLD_CYCLES      = 300;
  localparam int CYCLE_LIMIT      = 100000;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int MAX_PRINTED      = 100;

  typedef enum int {
    MODE_NONE,
    MODE_SEND,
    MODE_RECV,
    MODE_BOTH
  } idle_mode_t;

  // Sender link state as the block should hold it
  typedef struct packed {
    logic              tx_bit;
    logic              waiting;
    logic              linked;
    logic [WIN-1:0]    outcome;
    logic [SLOT_W-1:0] slot;
    logic [LOSS_W-1:0] losses;
    logic [TOL_W-1:0]  agreed;
    logic [TOL_W-1:0]  own_tol;
  } link_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_push   = 1'b0;
  in_item_t         in_data   = '0;
  logic             in_full;
  logic             out_empty;
  logic             out_pop   = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data  = '0;

  link_t      link_model;
  link_t      link_shadow;
  in_item_t   event_backlog[$];
  out_item_t  due_results[$];
  idle_mode_t mode       = MODE_NONE;
  int         errors     = 0;
  int         cycles     = 0;
  int         hold_asks  = 0;
  int         hold_taken = 0;
  int         hold_left  = 0;

  partial_reliability_stop_and_wait_top #(.WINDOW(WIN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic link_t link_after_reset();
    link_t s;
    s         = '0;
    s.outcome = '1;
    s.own_tol = TOL_RESET;
    return s;
  endfunction

  // Apply one link event to the state and return the outcome the block should report
  function automatic out_item_t advance_link(inout link_t s, input in_item_t ev);
    out_item_t        r;
    logic [TOL_W-1:0] peer_cap;
    logic [TOL_W-1:0] own_cap;
    r        = '0;
    r.action = ACT_IGNORED;
    case (ev.op)
      OP_SEND: begin
        if (!s.linked) begin
          r.action = ACT_REFUSED;
        end else if (!s.waiting) begin
          r.action  = ACT_TRANSMIT;
          r.seq_bit = s.tx_bit;
          s.tx_bit  = ~s.tx_bit;
          s.waiting = 1'b1;
        end
      end
      OP_ACK: begin
        if (s.waiting && ev.ack_bit == s.tx_bit) begin
          // mark the slot received, undo a loss recorded there
          if (!s.outcome[s.slot]) begin
            s.outcome[s.slot] = 1'b1;
            if (s.losses != '0) s.losses = s.losses - 1'b1;
          end
          s.slot    = (s.slot == SLOT_W'(WIN - 1)) ? '0 : s.slot + 1'b1;
          s.waiting = 1'b0;
          r.action  = ACT_DELIVERED;
          r.seq_bit = ~s.tx_bit;
        end
      end
      OP_TIMEOUT: begin
        if (s.waiting) begin
          // repeated timeouts on one message hit the same slot
          if (s.outcome[s.slot]) begin
            s.outcome[s.slot] = 1'b0;
            s.losses          = s.losses + 1'b1;
          end
          r.seq_bit = ~s.tx_bit;
          if (int'(s.losses) * 100 <= int'(s.agreed) * WIN) begin
            r.action  = ACT_GAVE_UP;
            s.tx_bit  = ~s.tx_bit;
            s.slot    = (s.slot == SLOT_W'(WIN - 1)) ? '0 : s.slot + 1'b1;
            s.waiting = 1'b0;
          end else begin
            r.action = ACT_RETRANSMIT;
          end
        end
      end
      default: begin
        if (!s.waiting) begin
          peer_cap = (ev.peer_tolerance > TOL_MAX) ? TOL_MAX : ev.peer_tolerance;
          own_cap  = (s.own_tol > TOL_MAX) ? TOL_MAX : s.own_tol;
          s.agreed = (peer_cap < own_cap) ? peer_cap : own_cap;
          s.linked = 1'b1;
          r.action = ACT_CONNECTED;
        end
      end
    endcase
    r.losses_in_window = s.losses;
    r.tolerance_in_use = s.agreed;
    return r;
  endfunction

  task automatic flag(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic logic idle_roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Append one event to the backlog, keeping the shadow state in step
  task automatic queue_event(input op_t op, input logic ack, input logic [TOL_W-1:0] peer);
    in_item_t ev;
    ev.op             = op;
    ev.ack_bit        = ack;
    ev.peer_tolerance = peer;
    void'(advance_link(link_shadow, ev));
    event_backlog.push_back(ev);
  endtask

  function automatic logic [TOL_W-1:0] pick_tolerance();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return TOL_W'($urandom_range(20));
    if (roll < 9) return TOL_W'($urandom_range(100));
    return TOL_W'($urandom_range(127));
  endfunction

  // Mostly well-formed exchanges with random content; a little noise on top
  task automatic queue_random(input int count);
    int        counted;
    int        roll;
    in_item_t  ev;
    out_item_t r;
    counted = 0;
    while (counted < count) begin
      roll              = $urandom_range(99);
      ev.op             = op_t'($urandom_range(3));
      ev.ack_bit        = 1'($urandom_range(1));
      ev.peer_tolerance = TOL_W'($urandom_range(127));
      if (roll >= 5) begin
        if (!link_shadow.linked || (!link_shadow.waiting && roll < 12)) begin
          ev.op             = OP_HANDSHAKE;
          ev.peer_tolerance = pick_tolerance();
        end else if (!link_shadow.waiting) begin
          ev.op = OP_SEND;
        end else if (roll < 55) begin
          ev.op      = OP_ACK;
          ev.ack_bit = link_shadow.tx_bit;
        end else if (roll < 88) begin
          ev.op = OP_TIMEOUT;
        end else if (roll < 94) begin
          ev.op      = OP_ACK;
          ev.ack_bit = ~link_shadow.tx_bit;
        end
      end
      r = advance_link(link_shadow, ev);
      event_backlog.push_back(ev);
      if (r.action != ACT_IGNORED) counted++;
    end
  endtask

  // Wait until every event has gone in and every outcome has come out
  task automatic drain();
    do @(posedge clk); while (event_backlog.size() != 0 || in_push || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid          <= 1'b0;
    link_model.own_tol  = tol;
    link_shadow.own_tol = tol;
  endtask

  task automatic run_phase(input logic [TOL_W-1:0] tol, input idle_mode_t m,
                           input logic squeeze);
    write_tolerance(tol);
    mode = m;
    queue_random(RANDOM_PER_PHASE);
    if (squeeze) hold_asks++;
    drain();
  endtask

  // Driver: offer backlog events, predict each one as it transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) due_results.push_back(advance_link(link_model, in_data));
      if (in_push && in_full) begin
        // hold the stalled event
      end else if (event_backlog.size() != 0 &&
                   !idle_roll(mode == MODE_SEND ? 57 : (mode == MODE_BOTH ? 8 : 0))) begin
        in_push <= 1'b1;
        in_data <= event_backlog.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each outcome transfer against the oldest prediction
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (due_results.size() == 0) begin
          flag("outcome transferred with nothing predicted");
        end else begin
          want = due_results.pop_front();
          if (out_data.action !== want.action)
            flag($sformatf("action %0d, predicted %0d", out_data.action, want.action));
          if (out_data.seq_bit !== want.seq_bit)
            flag($sformatf("seq_bit %0b, predicted %0b", out_data.seq_bit, want.seq_bit));
          if (out_data.losses_in_window !== want.losses_in_window)
            flag($sformatf("losses_in_window %0d, predicted %0d",
                           out_data.losses_in_window, want.losses_in_window));
          if (out_data.tolerance_in_use !== want.tolerance_in_use)
            flag($sformatf("tolerance_in_use %0d, predicted %0d",
                           out_data.tolerance_in_use, want.tolerance_in_use));
        end
      end
      out_pop <= (hold_left == 0) &&
                 !idle_roll(mode == MODE_RECV ? 57 : (mode == MODE_BOTH ? 8 : 0));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL partial_reliability_stop_and_wait_top");
      $finish;
    end
  end

  initial begin
    link_model  = link_after_reset();
    link_shadow = link_after_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events at the reset tolerance
    queue_event(OP_SEND, 1'b0, 7'd0);         // refused before connecting
    queue_event(OP_ACK, 1'b0, 7'd0);          // stray acknowledgement
    queue_event(OP_TIMEOUT, 1'b1, 7'd127);    // stray timeout
    queue_event(OP_HANDSHAKE, 1'b0, 7'd127);  // peer above 100 saturates
    queue_event(OP_HANDSHAKE, 1'b1, 7'd0);    // renegotiate down to zero
    queue_event(OP_SEND, 1'b0, 7'd0);
    queue_event(OP_SEND, 1'b0, 7'd0);         // already waiting
    queue_event(OP_HANDSHAKE, 1'b0, 7'd50);   // handshake while waiting
    queue_event(OP_ACK, 1'b0, 7'd0);          // wrong acknowledgement bit
    queue_event(OP_TIMEOUT, 1'b0, 7'd0);      // no tolerance: retransmit
    queue_event(OP_TIMEOUT, 1'b0, 7'd0);      // same slot, still one loss
    queue_event(OP_ACK, 1'b1, 7'd0);
    queue_event(OP_HANDSHAKE, 1'b0, 7'd100);
    queue_event(OP_SEND, 1'b0, 7'd0);
    queue_event(OP_TIMEOUT, 1'b0, 7'd0);      // within tolerance: give up
    queue_event(OP_SEND, 1'b0, 7'd0);         // abandoned bit sent again
    queue_event(OP_ACK, 1'b0, 7'd0);
    queue_event(OP_HANDSHAKE, 1'b0, 7'd7);
    queue_event(OP_SEND, 1'b0, 7'd0);
    queue_event(OP_TIMEOUT, 1'b0, 7'd0);
    queue_event(OP_TIMEOUT, 1'b0, 7'd0);
    queue_event(OP_ACK, 1'b1, 7'd0);
    drain();

    run_phase(7'd0, MODE_NONE, 1'b0);
    run_phase(7'd127, MODE_SEND, 1'b0);
    run_phase(7'd100, MODE_RECV, 1'b0);
    run_phase(7'd7, MODE_BOTH, 1'b0);
    run_phase(TOL_W'($urandom_range(127)), MODE_NONE, 1'b1);
    run_phase(TOL_W'($urandom_range(127)), MODE_BOTH, 1'b0);

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS partial_reliability_stop_and_wait_top");
    end else begin
      $display("FAIL partial_reliability_stop_and_wait_top");
    end
    $finish;
  end

endmodule
